FILE: sv/base32_byte_encoder_assert.svh
// Assertion macros for the base32 byte encoder.
// B32E_ASSERT checks a property on every clock edge outside reset.
// B32E_ASSERT_IMPL checks that one condition implies another in the same cycle.
`ifndef BASE32_BYTE_ENCODER_ASSERT_SVH
`define BASE32_BYTE_ENCODER_ASSERT_SVH
`ifndef SYNTH
`define B32E_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define B32E_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define B32E_ASSERT(lbl, clk, rst, prop, msg)
`define B32E_ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`endif
`endif

FILE: sv/b32e_pkg.sv
package b32e_pkg;

   localparam int BYTE_W    = 8;
   localparam int GROUP_W   = 5;
   localparam int CHAR_W    = 7;
   localparam int LEFT_W    = 4;
   localparam int CNT_W     = 3;
   localparam int MAX_CHARS = 3;
   localparam int IDX_W     = 2;
   localparam int WIN_W     = LEFT_W + BYTE_W + LEFT_W;

   localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h61; // 'a'
   localparam logic [CHAR_W-1:0]  CHAR_TWO  = 7'h32; // '2'
   localparam logic [GROUP_W-1:0] ALPHA_CNT = 5'd26;
   localparam logic [CNT_W-1:0]   CNT_MAX   = 3'd4;

   typedef logic [MAX_CHARS-1:0][CHAR_W-1:0] char_vec_type;

   // result of packing one byte: up to three characters plus next leftover
   typedef struct packed {
      char_vec_type           chars;
      logic [IDX_W-1:0]       last_idx;
      logic [LEFT_W-1:0]      new_bits;
      logic [CNT_W-1:0]       new_count;
   } pack_type;

   function automatic logic [CHAR_W-1:0] group_to_char(input logic [GROUP_W-1:0] v);
      if (v < ALPHA_CNT) begin
         return CHAR_A + CHAR_W'(v);
      end else begin
         return CHAR_TWO + CHAR_W'(v - ALPHA_CNT);
      end
   endfunction

endpackage

FILE: sv/b32e_pack.sv
module b32e_pack (
   input  logic [b32e_pkg::BYTE_W-1:0] data_byte,
   input  logic                        final_byte,
   input  logic [b32e_pkg::LEFT_W-1:0] leftover_bits,
   input  logic [b32e_pkg::CNT_W-1:0]  leftover_count,
   output b32e_pkg::pack_type          pack
);
   import b32e_pkg::*;

   logic [CNT_W-1:0]  cnt;
   logic [CNT_W-1:0]  shift;
   logic [WIN_W-1:0]  win;
   logic              two_full;
   logic [CNT_W-1:0]  rem;
   logic [LEFT_W-1:0] rem_mask;
   logic              tail;

   always_comb begin
      cnt      = (leftover_count > CNT_MAX) ? CNT_MAX : leftover_count;
      shift    = CNT_MAX - cnt;
      // valid bits left-aligned; zeros below give the right-hand fill
      win      = {leftover_bits, data_byte, {LEFT_W{1'b0}}} << shift;
      two_full = (cnt >= 3'd2);
      rem      = two_full ? (cnt - 3'd2) : (cnt + 3'd3);
      rem_mask = LEFT_W'((5'd1 << rem) - 5'd1);
      tail     = final_byte && (rem != '0);

      pack.chars[0] = group_to_char(win[WIN_W-1 -: GROUP_W]);
      pack.chars[1] = group_to_char(win[WIN_W-1-GROUP_W -: GROUP_W]);
      pack.chars[2] = group_to_char(win[WIN_W-1-2*GROUP_W -: GROUP_W]);
      pack.last_idx = IDX_W'(two_full) + IDX_W'(tail);
      pack.new_bits  = final_byte ? '0 : (data_byte[LEFT_W-1:0] & rem_mask);
      pack.new_count = final_byte ? '0 : rem;
   end

endmodule

FILE: sv/base32_byte_encoder.sv
// Lowercase base32 encoder (a-z, 2-7), no padding.
// Input channel req_: one byte a beat (req_data_byte), req_final_byte marks
// the last byte of a message. Result channel rsp_: one ASCII character a
// beat (rsp_code_char); rsp_end_of_text flags the message's last character.
// Each byte gives one or two characters, and a final byte carrying leftover
// bits gives one more, zero-filled on the right.
// With the buffer free, a byte passes through the input register and then
// the character buffer, which presents its first character on rsp_code_char.
// Throughput is set by the single result port, which drains one character
// a cycle from the buffer while rsp_ready is high; a byte yields one to
// three characters, 1.6 on average over a long message.
// The input register is freed as soon as the buffer takes its byte, so
// a new byte is accepted while the buffer's last character still waits.
// Reset (synchronous, active high) empties both stages and clears the
// leftover store. A stalled receiver holds the current character steady;
// once the buffer and the input register are full, req_ready drops.
`include "base32_byte_encoder_assert.svh"

module base32_byte_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [b32e_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                req_final_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [b32e_pkg::CHAR_W-1:0]         rsp_code_char,
   output logic                                rsp_end_of_text
);
   import b32e_pkg::*;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                in_final_ff;

   // leftover store
   logic [LEFT_W-1:0]   left_bits_ff, left_bits_in;
   logic [CNT_W-1:0]    left_cnt_ff, left_cnt_in;

   // character buffer
   logic                buf_valid_ff, buf_valid_in;
   char_vec_type        buf_chars_ff;
   logic [IDX_W-1:0]    buf_last_ff;
   logic                buf_final_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   pack_type            pack;
   logic                rsp_beat;
   logic                last_beat;
   logic                buf_free;
   logic                load;
   logic                req_beat;

   b32e_pack u_pack (
      .data_byte      (in_byte_ff),
      .final_byte     (in_final_ff),
      .leftover_bits  (left_bits_ff),
      .leftover_count (left_cnt_ff),
      .pack           (pack)
   );

   always_comb begin
      rsp_beat  = buf_valid_ff && rsp_ready;
      last_beat = (idx_ff == buf_last_ff);
      buf_free  = !buf_valid_ff || (rsp_beat && last_beat);
      load      = in_valid_ff && buf_free;
      req_ready = !in_valid_ff || load;
      req_beat  = req_valid && req_ready;

      in_valid_in  = req_beat || (in_valid_ff && !load);
      buf_valid_in = load || (buf_valid_ff && !(rsp_beat && last_beat));

      left_bits_in = load ? pack.new_bits  : left_bits_ff;
      left_cnt_in  = load ? pack.new_count : left_cnt_ff;

      if (load) begin
         idx_in = '0;
      end else if (rsp_beat) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         buf_valid_ff <= 1'b0;
         left_bits_ff <= '0;
         left_cnt_ff  <= '0;
         idx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         buf_valid_ff <= buf_valid_in;
         left_bits_ff <= left_bits_in;
         left_cnt_ff  <= left_cnt_in;
         idx_ff       <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_final_byte;
      end
      if (load) begin
         buf_chars_ff <= pack.chars;
         buf_last_ff  <= pack.last_idx;
         buf_final_ff <= in_final_ff;
      end
   end

   assign rsp_valid       = buf_valid_ff;
   assign rsp_code_char   = buf_chars_ff[idx_ff];
   assign rsp_end_of_text = buf_final_ff && last_beat;

   `B32E_ASSERT(a_left_cnt_range, clock, reset, left_cnt_ff <= CNT_MAX, "leftover count above four")
   `B32E_ASSERT_IMPL(a_idx_in_range, clock, reset, buf_valid_ff, idx_ff <= buf_last_ff, "buffer index past last character")
   `B32E_ASSERT_IMPL(a_eot_last, clock, reset, rsp_valid && rsp_end_of_text, buf_final_ff && idx_ff == buf_last_ff, "end flag off the last character")
   `B32E_ASSERT_IMPL(a_final_clears, clock, reset, load && in_final_ff, pack.new_count == '0 && pack.new_bits == '0, "final byte leaves bits behind")

endmodule
